FILE: rtl/edc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package edc_pkg;

	// quotient bits: |delta| stays below 2^34, two spare bits
	localparam int QW = 36;
	// numerator 4*P + den, divisor 2*den
	localparam int NW = 131;
	localparam int DW = 98;
	localparam int WW = DW + QW;

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic              hit;
		logic              go;
		logic              dxn;
		logic              dyn;
		logic              vxn;
		logic              vyn;
		logic [31:0]       dxm;
		logic [31:0]       dym;
		logic [31:0]       vxm;
		logic [31:0]       vym;
		logic [64:0]       dd;
		logic [31:0]       msum;
		logic [30:0]       ma;
		logic [30:0]       mb;
		logic signed [31:0] avx;
		logic signed [31:0] avy;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
	} item_t;

	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] count;
	} fifo_stat_t;

	typedef struct packed {
		logic              hit;
		logic              apply;
		logic              vneg;
		logic              dxn;
		logic              dyn;
		logic signed [31:0] avx;
		logic signed [31:0] avy;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
	} side_t;

	typedef struct packed {
		logic [63:0] ll;
		logic [62:0] lh;
		logic [64:0] hl;
		logic [63:0] hh;
	} pp_t;

	function automatic logic [31:0] abs33(input logic signed [32:0] v);
		logic [32:0] t;
		t = v[32] ? 33'(-v) : 33'(v);
		return t[31:0];
	endfunction

	function automatic logic [127:0] psum(input pp_t p);
		return {64'b0, p.ll} + ({65'b0, p.lh} << 32) + ({63'b0, p.hl} << 32)
			+ ({64'b0, p.hh} << 64);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [37:0] smax;
		logic signed [37:0] smin;
		smax = 38'sh007fffffff;
		smin = 38'sh3f80000000;
		if (v > smax) return 32'sh7fffffff;
		else if (v < smin) return 32'sh80000000;
		else return v[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/edc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module edc_front import edc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic signed [31:0] a_pos_x,
	input  wire logic signed [31:0] a_pos_y,
	input  wire logic signed [31:0] b_pos_x,
	input  wire logic signed [31:0] b_pos_y,
	input  wire logic signed [31:0] a_vel_x,
	input  wire logic signed [31:0] a_vel_y,
	input  wire logic signed [31:0] b_vel_x,
	input  wire logic signed [31:0] b_vel_y,
	input  wire logic [30:0]       a_radius,
	input  wire logic [30:0]       b_radius,
	input  wire logic [30:0]       a_mass,
	input  wire logic [30:0]       b_mass,
	output logic                   push,
	output item_t                  item
);

	logic              v_s1, v_s2;
	logic signed [32:0] dx_s1, dy_s1, vx_s1, vy_s1;
	logic [31:0]       rs_s1, msum_s1;
	logic [30:0]       ma_s1, mb_s1;
	logic signed [31:0] avx_s1, avy_s1, bvx_s1, bvy_s1;

	logic [31:0]       dxm, dym;
	logic              dxn_s2, dyn_s2, vxn_s2, vyn_s2;
	logic [31:0]       dxm_s2, dym_s2, vxm_s2, vym_s2;
	logic [63:0]       dx2_s2, dy2_s2, rs2_s2;
	logic [31:0]       msum_s2;
	logic [30:0]       ma_s2, mb_s2;
	logic signed [31:0] avx_s2, avy_s2, bvx_s2, bvy_s2;
	logic [64:0]       dd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= {b_pos_x[31], b_pos_x} - {a_pos_x[31], a_pos_x};
		dy_s1   <= {b_pos_y[31], b_pos_y} - {a_pos_y[31], a_pos_y};
		vx_s1   <= {a_vel_x[31], a_vel_x} - {b_vel_x[31], b_vel_x};
		vy_s1   <= {a_vel_y[31], a_vel_y} - {b_vel_y[31], b_vel_y};
		rs_s1   <= {1'b0, a_radius} + {1'b0, b_radius};
		msum_s1 <= {1'b0, a_mass} + {1'b0, b_mass};
		ma_s1   <= a_mass;
		mb_s1   <= b_mass;
		avx_s1  <= a_vel_x;
		avy_s1  <= a_vel_y;
		bvx_s1  <= b_vel_x;
		bvy_s1  <= b_vel_y;
	end

	always_comb begin
		dxm = abs33(dx_s1);
		dym = abs33(dy_s1);
	end

	always_ff @(posedge clk) begin
		dxn_s2  <= dx_s1[32];
		dyn_s2  <= dy_s1[32];
		vxn_s2  <= vx_s1[32];
		vyn_s2  <= vy_s1[32];
		dxm_s2  <= dxm;
		dym_s2  <= dym;
		vxm_s2  <= abs33(vx_s1);
		vym_s2  <= abs33(vy_s1);
		dx2_s2  <= 64'(dxm) * 64'(dxm);
		dy2_s2  <= 64'(dym) * 64'(dym);
		rs2_s2  <= 64'(rs_s1) * 64'(rs_s1);
		msum_s2 <= msum_s1;
		ma_s2   <= ma_s1;
		mb_s2   <= mb_s1;
		avx_s2  <= avx_s1;
		avy_s2  <= avy_s1;
		bvx_s2  <= bvx_s1;
		bvy_s2  <= bvy_s1;
	end

	// classify: contact test and whether the exchange has to run at all
	always_comb begin
		dd = {1'b0, dx2_s2} + {1'b0, dy2_s2};
		item.hit  = (dd <= {1'b0, rs2_s2});
		item.go   = item.hit && (dd != 65'd0) && (msum_s2 != 32'd0);
		item.dxn  = dxn_s2;
		item.dyn  = dyn_s2;
		item.vxn  = vxn_s2;
		item.vyn  = vyn_s2;
		item.dxm  = dxm_s2;
		item.dym  = dym_s2;
		item.vxm  = vxm_s2;
		item.vym  = vym_s2;
		item.dd   = dd;
		item.msum = msum_s2;
		item.ma   = ma_s2;
		item.mb   = mb_s2;
		item.avx  = avx_s2;
		item.avy  = avy_s2;
		item.bvx  = bvx_s2;
		item.bvy  = bvy_s2;
	end

	assign push = v_s2;

endmodule
`default_nettype wire

FILE: rtl/edc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module edc_fifo import edc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t wr_item,
	input  wire logic  pop,
	output item_t      rd_item,
	output fifo_stat_t stat
);

	item_t            mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_item    = mem[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule
`default_nettype wire

FILE: rtl/edc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per stage; needs n < d * 2^QW
module edc_div import edc_pkg::*; (
	input  wire logic          clk,
	input  wire logic [NW-1:0] n,
	input  wire logic [DW-1:0] d,
	output logic [QW-1:0]      q
);

	logic [WW-1:0] rem_s [QW];
	logic [DW-1:0] dv_s  [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int K = QW - 1 - i;
		logic [WW-1:0] rem_in;
		logic [DW-1:0] dv_in;
		logic [QW-1:0] quo_in;
		logic [WW:0]   trial;

		if (i == 0) begin : g_first
			assign rem_in = WW'(n);
			assign dv_in  = d;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign dv_in  = dv_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {1'b0, rem_in} - ({1'b0, WW'(dv_in)} << K);

		always_ff @(posedge clk) begin
			rem_s[i] <= trial[WW] ? rem_in : trial[WW-1:0];
			dv_s[i]  <= dv_in;
			quo_s[i] <= {quo_in[QW-2:0], ~trial[WW]};
		end
	end

	assign q = quo_s[QW-1];

endmodule
`default_nettype wire

FILE: rtl/edc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module edc_back import edc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire item_t in_item,
	output logic              done,
	output logic              hit,
	output logic signed [31:0] new_a_vel_x,
	output logic signed [31:0] new_a_vel_y,
	output logic signed [31:0] new_b_vel_x,
	output logic signed [31:0] new_b_vel_y
);

	logic val_b1, val_b2, val_b3, val_b4, val_b5, val_b6;
	logic val_d [QW];
	side_t side_b1, side_b2, side_b3, side_b4, side_b5, side_b6;
	side_t side_d [QW];

	logic [63:0]  p1_b1, p2_b1;
	logic         n1_b1, n2_b1;
	logic [62:0]  mc_b1 [4];
	logic [62:0]  mc_b2 [4];
	logic [62:0]  mc_b3 [4];
	logic [63:0]  den_lo_b1;
	logic [64:0]  den_hi_b1;
	logic signed [65:0] vd_b2;
	logic [96:0]  den_b2, den_b3, den_b4, den_b5;
	logic [64:0]  vdm_b3;
	logic         vdz_b3;
	pp_t          pp_b4 [4];
	logic [127:0] p_b5 [4];
	logic [NW-1:0] n_b6 [4];
	logic [DW-1:0] d_b6;
	logic [QW-1:0] q_div [4];

	logic signed [65:0] t1, t2;
	logic [65:0]        vd_abs;
	side_t              side_b3_n, side_b4_n;
	side_t              sd;
	logic               neg [4];
	logic signed [37:0] dlt [4];
	logic signed [37:0] sum [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_b1 <= 1'b0;
			val_b2 <= 1'b0;
			val_b3 <= 1'b0;
			val_b4 <= 1'b0;
			val_b5 <= 1'b0;
			val_b6 <= 1'b0;
			for (int i = 0; i < QW; i++) val_d[i] <= 1'b0;
			done <= 1'b0;
		end else begin
			val_b1 <= in_valid;
			val_b2 <= val_b1;
			val_b3 <= val_b2;
			val_b4 <= val_b3;
			val_b5 <= val_b4;
			val_b6 <= val_b5;
			val_d[0] <= val_b6;
			for (int i = 1; i < QW; i++) val_d[i] <= val_d[i-1];
			done <= val_d[QW-1];
		end
	end

	// b1: relative-velocity products, mass products, denominator partials
	always_ff @(posedge clk) begin
		side_b1.hit   <= in_item.hit;
		side_b1.apply <= in_item.go;
		side_b1.vneg  <= 1'b0;
		side_b1.dxn   <= in_item.dxn;
		side_b1.dyn   <= in_item.dyn;
		side_b1.avx   <= in_item.avx;
		side_b1.avy   <= in_item.avy;
		side_b1.bvx   <= in_item.bvx;
		side_b1.bvy   <= in_item.bvy;
		p1_b1     <= 64'(in_item.vxm) * 64'(in_item.dxm);
		p2_b1     <= 64'(in_item.vym) * 64'(in_item.dym);
		n1_b1     <= in_item.vxn ^ in_item.dxn;
		n2_b1     <= in_item.vyn ^ in_item.dyn;
		mc_b1[0]  <= 63'(in_item.dxm) * 63'(in_item.mb);
		mc_b1[1]  <= 63'(in_item.dym) * 63'(in_item.mb);
		mc_b1[2]  <= 63'(in_item.dxm) * 63'(in_item.ma);
		mc_b1[3]  <= 63'(in_item.dym) * 63'(in_item.ma);
		den_lo_b1 <= 64'(in_item.dd[31:0]) * 64'(in_item.msum);
		den_hi_b1 <= 65'(in_item.dd[64:32]) * 65'(in_item.msum);
	end

	always_comb begin
		t1 = n1_b1 ? -$signed({2'b00, p1_b1}) : $signed({2'b00, p1_b1});
		t2 = n2_b1 ? -$signed({2'b00, p2_b1}) : $signed({2'b00, p2_b1});
		vd_abs = vd_b2[65] ? 66'(-vd_b2) : 66'(vd_b2);
		// dot-product sign joins the side info with the magnitude
		side_b3_n = side_b2;
		side_b3_n.vneg = vd_b2[65];
		side_b4_n = side_b3;
		side_b4_n.apply = side_b3.apply & ~vdz_b3;
	end

	// b2: signed dot product; b3: its magnitude
	always_ff @(posedge clk) begin
		side_b2 <= side_b1;
		vd_b2   <= t1 + t2;
		den_b2  <= {den_hi_b1, 32'b0} + 97'(den_lo_b1);
		mc_b2   <= mc_b1;

		side_b3 <= side_b3_n;
		vdm_b3  <= vd_abs[64:0];
		vdz_b3  <= (vd_b2 == '0);
		den_b3  <= den_b2;
		mc_b3   <= mc_b2;
	end

	// b4: numerator partial products; b5: their sum; b6: rounding offset
	always_ff @(posedge clk) begin
		side_b4       <= side_b4_n;
		den_b4        <= den_b3;
		for (int j = 0; j < 4; j++) begin
			pp_b4[j].ll <= 64'(vdm_b3[31:0]) * 64'(mc_b3[j][31:0]);
			pp_b4[j].lh <= 63'(vdm_b3[31:0]) * 63'(mc_b3[j][62:32]);
			pp_b4[j].hl <= 65'(vdm_b3[64:32]) * 65'(mc_b3[j][31:0]);
			pp_b4[j].hh <= 64'(vdm_b3[64:32]) * 64'(mc_b3[j][62:32]);
		end

		side_b5 <= side_b4;
		den_b5  <= den_b4;
		for (int j = 0; j < 4; j++) p_b5[j] <= psum(pp_b4[j]);

		side_b6 <= side_b5;
		d_b6    <= {den_b5, 1'b0};
		for (int j = 0; j < 4; j++) n_b6[j] <= {1'b0, p_b5[j], 2'b00} + NW'(den_b5);
	end

	for (genvar j = 0; j < 4; j++) begin : g_div
		edc_div u_div (
			.clk (clk),
			.n   (n_b6[j]),
			.d   (d_b6),
			.q   (q_div[j])
		);
	end

	always_ff @(posedge clk) begin
		side_d[0] <= side_b6;
		for (int i = 1; i < QW; i++) side_d[i] <= side_d[i-1];
	end

	always_comb begin
		sd = side_d[QW-1];
		neg[0] = sd.vneg ^ sd.dxn;
		neg[1] = sd.vneg ^ sd.dyn;
		neg[2] = sd.vneg ^ sd.dxn;
		neg[3] = sd.vneg ^ sd.dyn;
		for (int j = 0; j < 4; j++) begin
			dlt[j] = neg[j] ? -$signed({2'b00, q_div[j]}) : $signed({2'b00, q_div[j]});
		end
		sum[0] = 38'(sd.avx) - dlt[0];
		sum[1] = 38'(sd.avy) - dlt[1];
		sum[2] = 38'(sd.bvx) + dlt[2];
		sum[3] = 38'(sd.bvy) + dlt[3];
	end

	always_ff @(posedge clk) begin
		hit         <= sd.hit;
		new_a_vel_x <= sd.apply ? sat32(sum[0]) : sd.avx;
		new_a_vel_y <= sd.apply ? sat32(sum[1]) : sd.avy;
		new_b_vel_x <= sd.apply ? sat32(sum[2]) : sd.bvx;
		new_b_vel_y <= sd.apply ? sat32(sum[3]) : sd.bvy;
	end

endmodule
`default_nettype wire

FILE: rtl/elastic_disc_collision.sv
`timescale 1ns / 1ps
`default_nettype none
// Elastic collision of two discs. One pair is taken per cycle (start while busy is low)
// and its result appears for one cycle with done, after the front end, the queue and the
// back end, whose 36-stage radix-2 divider runs four quotients in parallel.
// Results come out in order and cannot be held off: the receiver must take them on done.
// An 8-entry queue sits between the contact classifier and the arithmetic; busy rises
// only when it nears full, which a steady stream never reaches.
module elastic_disc_collision import edc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic signed [31:0] a_pos_x,
	input  wire logic signed [31:0] a_pos_y,
	input  wire logic signed [31:0] b_pos_x,
	input  wire logic signed [31:0] b_pos_y,
	input  wire logic signed [31:0] a_vel_x,
	input  wire logic signed [31:0] a_vel_y,
	input  wire logic signed [31:0] b_vel_x,
	input  wire logic signed [31:0] b_vel_y,
	input  wire logic [30:0]       a_radius,
	input  wire logic [30:0]       b_radius,
	input  wire logic [30:0]       a_mass,
	input  wire logic [30:0]       b_mass,
	output logic                   done,
	output logic                   hit,
	output logic signed [31:0]     new_a_vel_x,
	output logic signed [31:0]     new_a_vel_y,
	output logic signed [31:0]     new_b_vel_x,
	output logic signed [31:0]     new_b_vel_y
);

	localparam int ACC_LAT = QW + 10;
	localparam logic [CNT_W-1:0] BUSY_AT = CNT_W'(FIFO_DEPTH - 3);

	logic       accept;
	logic       push;
	logic       pop;
	item_t      wr_item, rd_item;
	fifo_stat_t stat;

	// two front stages may still be in flight when the queue is checked
	assign busy   = (stat.count >= BUSY_AT);
	assign accept = start && !busy;
	assign pop    = !stat.empty;

	edc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.a_pos_x  (a_pos_x),
		.a_pos_y  (a_pos_y),
		.b_pos_x  (b_pos_x),
		.b_pos_y  (b_pos_y),
		.a_vel_x  (a_vel_x),
		.a_vel_y  (a_vel_y),
		.b_vel_x  (b_vel_x),
		.b_vel_y  (b_vel_y),
		.a_radius (a_radius),
		.b_radius (b_radius),
		.a_mass   (a_mass),
		.b_mass   (b_mass),
		.push     (push),
		.item     (wr_item)
	);

	edc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.stat    (stat)
	);

	edc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pop),
		.in_item     (rd_item),
		.done        (done),
		.hit         (hit),
		.new_a_vel_x (new_a_vel_x),
		.new_a_vel_y (new_a_vel_y),
		.new_b_vel_x (new_b_vel_x),
		.new_b_vel_y (new_b_vel_y)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##ACC_LAT done)
		else $error("transaction result missing at fixed latency");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && stat.count == CNT_W'(FIFO_DEPTH)))
		else $error("queue overflow");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.count == $past(stat.count)) || (stat.count == $past(stat.count) + 1'b1)
		|| (stat.count + 1'b1 == $past(stat.count)))
		else $error("queue count jumped");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import edc_pkg::*;

	typedef struct {
		logic signed [31:0] apx, apy, bpx, bpy, avx, avy, bvx, bvy;
		logic [30:0] ra, rb, ma, mb;
	} pair_t;

	typedef struct {
		logic hit;
		logic signed [31:0] nax, nay, nbx, nby;
	} bounce_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, hit;
	logic signed [31:0] new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y;
	pair_t cur = '{default: '0};

	pair_t pending_pairs[$];
	bounce_t expected_bounces[$];
	int errors = 0;
	int stall_cycles = 0;
	int sent = 0;
	logic took = 0;
	logic feed_done = 0;

	always #5 clk = ~clk;

	elastic_disc_collision i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_pos_x(cur.apx), .a_pos_y(cur.apy), .b_pos_x(cur.bpx), .b_pos_y(cur.bpy),
		.a_vel_x(cur.avx), .a_vel_y(cur.avy), .b_vel_x(cur.bvx), .b_vel_y(cur.bvy),
		.a_radius(cur.ra), .b_radius(cur.rb), .a_mass(cur.ma), .b_mass(cur.mb),
		.done(done), .hit(hit),
		.new_a_vel_x(new_a_vel_x), .new_a_vel_y(new_a_vel_y),
		.new_b_vel_x(new_b_vel_x), .new_b_vel_y(new_b_vel_y)
	);

	function automatic logic signed [31:0] clamp32(input logic signed [199:0] v);
		if (v > 200'sd2147483647) return 32'sh7fffffff;
		if (v < -200'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// rounded 2*m*(v.d)*c / (M*|d|^2), ties away from zero
	function automatic logic signed [199:0] impulse(input logic signed [199:0] vd,
			input logic signed [199:0] c, input logic signed [199:0] m,
			input logic signed [199:0] den);
		logic signed [199:0] p, mag, q;
		p = vd * m * c * 2;
		mag = p < 0 ? -p : p;
		q = (2 * mag + den) / (2 * den);
		return p < 0 ? -q : q;
	endfunction

	function automatic bounce_t predict_bounce(input pair_t s);
		bounce_t r;
		logic signed [199:0] dx, dy, vx, vy, dd, rs, ms, vd, den, ax, ay, bx, by;
		dx = 200'(s.bpx) - 200'(s.apx);
		dy = 200'(s.bpy) - 200'(s.apy);
		ax = 200'(s.avx); ay = 200'(s.avy); bx = 200'(s.bvx); by = 200'(s.bvy);
		dd = dx * dx + dy * dy;
		rs = 200'(s.ra) + 200'(s.rb);
		ms = 200'(s.ma) + 200'(s.mb);
		r.hit = dd <= rs * rs;
		if (r.hit && dd != 0 && ms != 0) begin
			vx = ax - bx;
			vy = ay - by;
			vd = vx * dx + vy * dy;
			den = dd * ms;
			if (vd != 0) begin
				ax = ax - impulse(vd, dx, 200'(s.mb), den);
				ay = ay - impulse(vd, dy, 200'(s.mb), den);
				bx = bx + impulse(vd, dx, 200'(s.ma), den);
				by = by + impulse(vd, dy, 200'(s.ma), den);
			end
		end
		r.nax = clamp32(ax); r.nay = clamp32(ay);
		r.nbx = clamp32(bx); r.nby = clamp32(by);
		return r;
	endfunction

	function automatic logic [31:0] rnd_scaled();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	function automatic pair_t rand_pair(input int mode);
		pair_t s;
		logic signed [31:0] dx, dy;
		logic [32:0] span;
		s.apx = $urandom; s.apy = $urandom;
		s.avx = rnd_scaled(); s.avy = rnd_scaled();
		s.bvx = rnd_scaled(); s.bvy = rnd_scaled();
		s.ma = 31'($urandom >> $urandom_range(1, 31));
		s.mb = 31'($urandom >> $urandom_range(1, 31));
		if (s.ma == '0) s.ma = 31'd1;
		if (s.mb == '0) s.mb = 31'd1;
		if (mode < 7) begin
			// contact geometry: offset small enough that radii can cover it
			dx = $signed($urandom) >>> $urandom_range(2, 31);
			dy = $signed($urandom) >>> $urandom_range(2, 31);
			s.bpx = s.apx + dx; s.bpy = s.apy + dy;
			span = 33'(dx < 0 ? -dx : dx) + 33'(dy < 0 ? -dy : dy);
			if (span > 33'h7fffffff) span = 33'h7fffffff;
			s.ra = span[30:0] >> $urandom_range(0, 2);
			s.rb = 31'(span[30:0] - s.ra + 31'($urandom & 32'hff));
			if ($urandom_range(0, 5) == 0) s.rb = span[30:0] - s.ra - 31'd1;
		end else begin
			s.bpx = $urandom; s.bpy = $urandom;
			s.ra = 31'($urandom); s.rb = 31'($urandom);
			s.ma = 31'($urandom); s.mb = 31'($urandom);
			if (s.ma == '0) s.ma = 31'd1;
			if (s.mb == '0) s.mb = 31'd1;
		end
		return s;
	endfunction

	// driver: presents the next transaction at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_pairs.size() > 0 &&
					((sent > 700 && sent < 1000) || $urandom_range(0, 99) >= 31)) begin
				cur <= pending_pairs.pop_front();
				start <= 1;
				sent++;
			end else begin
				start <= 0;
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		bounce_t e;
		took <= start && !busy;
		if (start && !busy) expected_bounces.push_back(predict_bounce(cur));
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (done) begin
			if (expected_bounces.size() == 0) begin
				$display("%0t: unexpected result hit=%0b", $time, hit);
				errors++;
			end else begin
				e = expected_bounces.pop_front();
				if (hit !== e.hit) begin
					$display("%0t: hit exp %0b got %0b", $time, e.hit, hit);
					errors++;
				end
				if (new_a_vel_x !== e.nax) begin
					$display("%0t: new_a_vel_x exp %0d got %0d", $time, e.nax, new_a_vel_x);
					errors++;
				end
				if (new_a_vel_y !== e.nay) begin
					$display("%0t: new_a_vel_y exp %0d got %0d", $time, e.nay, new_a_vel_y);
					errors++;
				end
				if (new_b_vel_x !== e.nbx) begin
					$display("%0t: new_b_vel_x exp %0d got %0d", $time, e.nbx, new_b_vel_x);
					errors++;
				end
				if (new_b_vel_y !== e.nby) begin
					$display("%0t: new_b_vel_y exp %0d got %0d", $time, e.nby, new_b_vel_y);
					errors++;
				end
			end
		end
		if (stall_cycles > 3000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		pair_t s;
		int k;
		// head-on, equal masses
		s = '{apx: 0, apy: 0, bpx: 32'sh10000, bpy: 0, avx: 32'sh10000, avy: 0,
			bvx: -32'sh10000, bvy: 0, ra: 31'h8000, rb: 31'h8000,
			ma: 31'h10000, mb: 31'h10000};
		pending_pairs.push_back(s);
		// just apart
		s.rb = 31'h7fff; pending_pairs.push_back(s);
		// coincident centres
		s.bpx = 0; pending_pairs.push_back(s);
		// zero relative velocity
		s.bpx = 32'sh8000; s.bvx = s.avx; pending_pairs.push_back(s);
		// oblique, unequal masses
		s = '{apx: -32'sh30000, apy: 32'sh20000, bpx: -32'sh10000, bpy: 32'sh38000,
			avx: 32'sh5000, avy: -32'sh2000, bvx: -32'sh7000, bvy: 32'sh1234,
			ra: 31'h18000, rb: 31'h14000, ma: 31'h1, mb: 31'h7fffffff};
		pending_pairs.push_back(s);
		s.ma = 31'h7fffffff; s.mb = 31'h1; pending_pairs.push_back(s);
		// saturation: extreme opposing velocities, light disc hit by heavy one
		s = '{apx: 0, apy: 0, bpx: 1, bpy: 1, avx: 32'sh7fffffff, avy: 32'sh7fffffff,
			bvx: 32'sh80000000, bvy: 32'sh80000000, ra: 31'h7fffffff, rb: 31'h7fffffff,
			ma: 31'h7fffffff, mb: 31'h1};
		pending_pairs.push_back(s);
		s.ma = 31'h1; s.mb = 31'h7fffffff; pending_pairs.push_back(s);
		// extreme positions, full radii
		s.apx = 32'sh80000000; s.apy = 32'sh80000000;
		s.bpx = 32'sh7fffffff; s.bpy = 32'sh7fffffff; pending_pairs.push_back(s);
		s.ra = '0; s.rb = '0; pending_pairs.push_back(s);
		s.apx = 32'sh7fffffff; s.bpx = 32'sh80000000; s.apy = 0; s.bpy = 0;
		s.ra = 31'h7fffffff; pending_pairs.push_back(s);
		// zero radii, same centre
		s = '{default: '0}; s.ma = 31'd1; s.mb = 31'd1; s.avx = -5; pending_pairs.push_back(s);
		for (k = 0; k < 1950; k++) pending_pairs.push_back(rand_pair($urandom_range(0, 9)));

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (pending_pairs.size() == 0);
		@(posedge clk);
		while (start || expected_bounces.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

FILE: files.f
rtl/edc_pkg.sv
rtl/edc_front.sv
rtl/edc_fifo.sv
rtl/edc_div.sv
rtl/edc_back.sv
rtl/elastic_disc_collision.sv
tb/tb_top.sv
